// File: src/bbc_pkg.sv
// Package of the block buffer cache tag manager: sizes, codes, payload types
// and the command and status structs between controller and datapath.
// Depends on nothing; the datapath, controller, top level and testbench use it.
package bbc_pkg;

    // Sizes of the pool
    localparam int SLOT_COUNT   = 8;
    localparam int STAMP_BITS   = 16;
    localparam int BLOCK_BITS   = 16;
    localparam int RESULT_LIMIT = 8;
    localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W        = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_ZERO    = 2'd2,
        KIND_SYNC    = 2'd3
    } t_kind;

    // Fill modes
    localparam logic [1:0] FILL_READ    = 2'd0;
    localparam logic [1:0] FILL_REWRITE = 2'd1;
    localparam logic [1:0] FILL_ZERO    = 2'd2;

    // Dirty levels on release
    localparam logic [1:0] LVL_CLEAN = 2'd0;
    localparam logic [1:0] LVL_DIRTY = 2'd1;
    localparam logic [1:0] LVL_WRITE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_NOBUF = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_EMIT1,
        S_EMIT2,
        S_REL,
        S_SYNC
    } t_state;

    // Slot pointer operations
    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_MATCH,
        PTR_VICT
    } t_ptr_op;

    // Result to emit, with the tag update that goes with it
    typedef enum logic [3:0] {
        RES_NONE,
        RES_HIT,
        RES_BUSY,
        RES_NOBUF,
        RES_FLUSH,
        RES_FILL,
        RES_ZERO,
        RES_REL,
        RES_SYNC,
        RES_SYNC_NONE
    } t_res;

    // Request payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  device;
        logic [15:0] block;
        logic [1:0]  fill_mode;
        logic [2:0]  slot;
        logic [1:0]  dirty_level;
    } t_req_pay;

    // Result payload
    typedef struct packed {
        logic [2:0]  slot_used;
        logic        hit;
        logic        fill_read;
        logic        clear_data;
        logic        write_out;
        logic [7:0]  write_device;
        logic [15:0] write_block;
        logic [1:0]  status;
        logic        last;
    } t_res_pay;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_step;
        t_ptr_op ptr_op;
        t_res    res;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  scan_last;
        logic  found;
        logic  match_busy;
        logic  vfound;
        logic  vict_named_dirty;
        logic  sync_any;
        logic  sync_bit;
        logic  sync_last;
        logic  out_space;
    } t_stat;

endpackage

// File: src/bbc_req_if.sv
// Request channel of the buffer cache tag manager: valid, ready and payload.
// Depends on nothing.
interface bbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  device;
    logic [15:0] block;
    logic [1:0]  fill_mode;
    logic [2:0]  slot;
    logic [1:0]  dirty_level;

    modport source (output valid, kind, device, block, fill_mode, slot, dirty_level,
                    input ready);
    modport sink   (input valid, kind, device, block, fill_mode, slot, dirty_level,
                    output ready);
endinterface

// File: src/bbc_res_if.sv
// Result channel of the buffer cache tag manager: valid, ready and payload.
// Depends on nothing.
interface bbc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  slot_used;
    logic        hit;
    logic        fill_read;
    logic        clear_data;
    logic        write_out;
    logic [7:0]  write_device;
    logic [15:0] write_block;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, slot_used, hit, fill_read, clear_data, write_out,
                    write_device, write_block, status, last, input ready);
    modport sink   (input valid, slot_used, hit, fill_read, clear_data, write_out,
                    write_device, write_block, status, last, output ready);
endinterface

// File: src/bbc_dpath.sv
// Datapath of the buffer cache tag manager: slot tags, use clock, scan
// registers and the result output register.
// Depends on bbc_pkg.
module bbc_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbc_pkg::t_cmd     i_cmd,
    input  bbc_pkg::t_req_pay i_req,
    input  logic              i_out_ready,
    output bbc_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output bbc_pkg::t_res_pay o_out
);

    // Slot tags
    logic [bbc_pkg::SLOT_COUNT-1:0] r_valid;
    logic [bbc_pkg::SLOT_COUNT-1:0] r_dirty;
    logic [bbc_pkg::SLOT_COUNT-1:0] r_busy;
    logic [7:0]                     r_dev   [bbc_pkg::SLOT_COUNT];
    logic [bbc_pkg::BLOCK_BITS-1:0] r_blk   [bbc_pkg::SLOT_COUNT];
    logic [bbc_pkg::STAMP_BITS-1:0] r_stamp [bbc_pkg::SLOT_COUNT];
    logic [bbc_pkg::STAMP_BITS-1:0] r_clock;

    // Latched request
    bbc_pkg::t_kind                 r_kind;
    logic [7:0]                     r_dev_q;
    logic [bbc_pkg::BLOCK_BITS-1:0] r_blk_q;
    logic [1:0]                     r_mode;
    logic [2:0]                     r_slot;
    logic [1:0]                     r_lvl;

    // Scan state
    logic [bbc_pkg::IDX_W-1:0]      r_ptr;
    logic [bbc_pkg::IDX_W-1:0]      r_match;
    logic [bbc_pkg::IDX_W-1:0]      r_vict;
    logic                           r_found;
    logic                           r_vfound;
    logic [bbc_pkg::STAMP_BITS-1:0] r_best_age;
    logic [bbc_pkg::CNT_W-1:0]      r_cnt;

    // Output register
    logic              r_out_valid;
    bbc_pkg::t_res_pay r_out;
    bbc_pkg::t_res_pay n_out;

    logic                           rd_valid;
    logic                           rd_dirty;
    logic                           rd_busy;
    logic [7:0]                     rd_dev;
    logic [bbc_pkg::BLOCK_BITS-1:0] rd_blk;
    logic [bbc_pkg::STAMP_BITS-1:0] age;
    logic [bbc_pkg::STAMP_BITS-1:0] n_clock;
    logic [bbc_pkg::SLOT_COUNT-1:0] sync_mask;
    logic                           sync_more;
    logic                           sync_last;
    logic                           rel_oor;
    logic                           tag_hit;
    logic                           out_space;

    // Single read port at the slot pointer
    assign rd_valid = r_valid[r_ptr];
    assign rd_dirty = r_dirty[r_ptr];
    assign rd_busy  = r_busy[r_ptr];
    assign rd_dev   = r_dev[r_ptr];
    assign rd_blk   = r_blk[r_ptr];
    assign age      = r_clock - r_stamp[r_ptr];
    assign n_clock  = r_clock + bbc_pkg::STAMP_BITS'(1);
    assign tag_hit  = rd_valid && (rd_dev == r_dev_q) && (rd_blk == r_blk_q);
    assign rel_oor  = (int'(r_slot) >= bbc_pkg::SLOT_COUNT);
    assign out_space = !r_out_valid || i_out_ready;

    // Sync: named dirty slots, and whether one lies above the pointer
    assign sync_mask = r_valid & r_dirty;
    always_comb begin
        sync_more = 1'b0;
        for (int i = 0; i < bbc_pkg::SLOT_COUNT; i++) begin
            if (sync_mask[i] && (bbc_pkg::IDX_W'(i) > r_ptr)) begin
                sync_more = 1'b1;
            end
        end
    end
    assign sync_last = !sync_more ||
                       (r_cnt == bbc_pkg::CNT_W'(bbc_pkg::RESULT_LIMIT - 1));

    // Status to controller
    always_comb begin
        o_stat.kind             = r_kind;
        o_stat.scan_last        = (r_ptr == bbc_pkg::IDX_W'(bbc_pkg::SLOT_COUNT - 1));
        o_stat.found            = r_found;
        o_stat.match_busy       = rd_busy;
        o_stat.vfound           = r_vfound;
        o_stat.vict_named_dirty = rd_valid && rd_dirty;
        o_stat.sync_any         = |sync_mask;
        o_stat.sync_bit         = sync_mask[r_ptr];
        o_stat.sync_last        = sync_last;
        o_stat.out_space        = out_space;
    end

    // Result payload for the emitted code
    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        unique case (i_cmd.res)
            bbc_pkg::RES_HIT: begin
                n_out.slot_used = 3'(r_ptr);
                n_out.hit       = 1'b1;
            end
            bbc_pkg::RES_BUSY: begin
                n_out.slot_used = 3'(r_ptr);
                n_out.hit       = 1'b1;
                n_out.status    = bbc_pkg::ST_BUSY;
            end
            bbc_pkg::RES_NOBUF: begin
                n_out.status = bbc_pkg::ST_NOBUF;
            end
            bbc_pkg::RES_FLUSH: begin
                n_out.slot_used    = 3'(r_ptr);
                n_out.write_out    = 1'b1;
                n_out.write_device = rd_dev;
                n_out.write_block  = 16'(rd_blk);
                n_out.last         = 1'b0;
            end
            bbc_pkg::RES_FILL: begin
                n_out.slot_used  = 3'(r_ptr);
                n_out.fill_read  = (r_mode == bbc_pkg::FILL_READ);
                n_out.clear_data = (r_mode == bbc_pkg::FILL_ZERO);
            end
            bbc_pkg::RES_ZERO: begin
                n_out.slot_used  = 3'(r_ptr);
                n_out.clear_data = 1'b1;
            end
            bbc_pkg::RES_REL: begin
                n_out.slot_used = r_slot;
                if (!rel_oor && (r_lvl == bbc_pkg::LVL_WRITE) && rd_valid) begin
                    n_out.write_out    = 1'b1;
                    n_out.write_device = rd_dev;
                    n_out.write_block  = 16'(rd_blk);
                end
            end
            bbc_pkg::RES_SYNC: begin
                n_out.slot_used    = 3'(r_ptr);
                n_out.write_out    = 1'b1;
                n_out.write_device = rd_dev;
                n_out.write_block  = 16'(rd_blk);
                n_out.last         = sync_last;
            end
            default: ;
        endcase
    end

    // Flags, stamps and clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_busy  <= '0;
            r_clock <= '0;
            for (int i = 0; i < bbc_pkg::SLOT_COUNT; i++) begin
                r_stamp[i] <= '0;
            end
        end else begin
            unique case (i_cmd.res)
                bbc_pkg::RES_HIT: begin
                    r_clock        <= n_clock;
                    r_stamp[r_ptr] <= n_clock;
                    r_busy[r_ptr]  <= 1'b1;
                end
                bbc_pkg::RES_FILL: begin
                    r_clock        <= n_clock;
                    r_stamp[r_ptr] <= n_clock;
                    r_busy[r_ptr]  <= 1'b1;
                    r_valid[r_ptr] <= 1'b1;
                    r_dirty[r_ptr] <= 1'b0;
                end
                bbc_pkg::RES_ZERO: begin
                    r_valid[r_ptr] <= 1'b0;
                    r_dirty[r_ptr] <= 1'b0;
                end
                bbc_pkg::RES_REL: begin
                    if (!rel_oor) begin
                        r_busy[r_ptr]  <= 1'b0;
                        r_dirty[r_ptr] <= (r_lvl == bbc_pkg::LVL_WRITE) ? 1'b0 :
                                          (rd_dirty || (r_lvl != bbc_pkg::LVL_CLEAN));
                    end
                end
                default: ;
            endcase
        end
    end

    // Names: written only when a slot is renamed
    always_ff @(posedge i_clk) begin
        if (i_cmd.res == bbc_pkg::RES_FILL) begin
            r_dev[r_ptr] <= r_dev_q;
            r_blk[r_ptr] <= r_blk_q;
        end
    end

    // Latched request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dev_q <= i_req.device;
            r_blk_q <= bbc_pkg::BLOCK_BITS'(i_req.block);
            r_mode  <= i_req.fill_mode;
            r_slot  <= i_req.slot;
            r_lvl   <= i_req.dirty_level;
        end
    end

    // Pointer, scan results and sync count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= bbc_pkg::KIND_ACQUIRE;
            r_ptr      <= '0;
            r_match    <= '0;
            r_vict     <= '0;
            r_found    <= 1'b0;
            r_vfound   <= 1'b0;
            r_best_age <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.load) begin
            r_kind   <= bbc_pkg::t_kind'(i_req.kind);
            r_ptr    <= (i_req.kind == bbc_pkg::KIND_RELEASE) ?
                        bbc_pkg::IDX_W'(i_req.slot) : '0;
            r_found  <= 1'b0;
            r_vfound <= 1'b0;
            r_vict   <= '0;
            r_cnt    <= '0;
        end else begin
            // One slot per step: lowest tag match, oldest idle slot
            if (i_cmd.scan_step) begin
                if (tag_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_match <= r_ptr;
                end
                if (!rd_busy && (!r_vfound || (age >= r_best_age))) begin
                    r_vfound   <= 1'b1;
                    r_vict     <= r_ptr;
                    r_best_age <= age;
                end
            end
            if (i_cmd.res == bbc_pkg::RES_SYNC) begin
                r_cnt <= r_cnt + bbc_pkg::CNT_W'(1);
            end
            case (i_cmd.ptr_op)
                bbc_pkg::PTR_INC:   r_ptr <= r_ptr + bbc_pkg::IDX_W'(1);
                bbc_pkg::PTR_MATCH: r_ptr <= r_match;
                bbc_pkg::PTR_VICT:  r_ptr <= r_vict;
                default: ;
            endcase
        end
    end

    // Output register: loads on emit, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res != bbc_pkg::RES_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res != bbc_pkg::RES_NONE) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: src/bbc_ctrl.sv
// Controller of the buffer cache tag manager: sequences the tag scan and the
// results of each request.
// Depends on bbc_pkg.
module bbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  bbc_pkg::t_stat i_stat,
    output logic           o_req_ready,
    output bbc_pkg::t_cmd  o_cmd
);

    bbc_pkg::t_state r_state;
    bbc_pkg::t_state n_state;
    logic            is_acq;
    bbc_pkg::t_res   final_res;

    assign is_acq    = (i_stat.kind == bbc_pkg::KIND_ACQUIRE);
    assign final_res = is_acq ? bbc_pkg::RES_FILL : bbc_pkg::RES_ZERO;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_req_ready     = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.ptr_op    = bbc_pkg::PTR_HOLD;
        o_cmd.res       = bbc_pkg::RES_NONE;
        unique case (r_state)
            bbc_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bbc_pkg::S_DISPATCH;
                end
            end
            bbc_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    bbc_pkg::KIND_RELEASE: n_state = bbc_pkg::S_REL;
                    bbc_pkg::KIND_SYNC:    n_state = bbc_pkg::S_SYNC;
                    default:               n_state = bbc_pkg::S_SCAN;
                endcase
            end
            bbc_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = bbc_pkg::S_DECIDE;
                end else begin
                    o_cmd.ptr_op = bbc_pkg::PTR_INC;
                end
            end
            bbc_pkg::S_DECIDE: begin
                o_cmd.ptr_op = (is_acq && i_stat.found) ? bbc_pkg::PTR_MATCH :
                                                          bbc_pkg::PTR_VICT;
                n_state      = bbc_pkg::S_EMIT1;
            end
            bbc_pkg::S_EMIT1: begin
                if (i_stat.out_space) begin
                    if (is_acq && i_stat.found) begin
                        o_cmd.res = i_stat.match_busy ? bbc_pkg::RES_BUSY :
                                                        bbc_pkg::RES_HIT;
                        n_state   = bbc_pkg::S_IDLE;
                    end else if (!i_stat.vfound) begin
                        o_cmd.res = bbc_pkg::RES_NOBUF;
                        n_state   = bbc_pkg::S_IDLE;
                    end else if (i_stat.vict_named_dirty) begin
                        o_cmd.res = bbc_pkg::RES_FLUSH;
                        n_state   = bbc_pkg::S_EMIT2;
                    end else begin
                        o_cmd.res = final_res;
                        n_state   = bbc_pkg::S_IDLE;
                    end
                end
            end
            bbc_pkg::S_EMIT2: begin
                if (i_stat.out_space) begin
                    o_cmd.res = final_res;
                    n_state   = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_REL: begin
                if (i_stat.out_space) begin
                    o_cmd.res = bbc_pkg::RES_REL;
                    n_state   = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_SYNC: begin
                // Walk the slots, reporting each named dirty one
                if (!i_stat.sync_any) begin
                    if (i_stat.out_space) begin
                        o_cmd.res = bbc_pkg::RES_SYNC_NONE;
                        n_state   = bbc_pkg::S_IDLE;
                    end
                end else if (i_stat.sync_bit) begin
                    if (i_stat.out_space) begin
                        o_cmd.res = bbc_pkg::RES_SYNC;
                        if (i_stat.sync_last) begin
                            n_state = bbc_pkg::S_IDLE;
                        end else begin
                            o_cmd.ptr_op = bbc_pkg::PTR_INC;
                        end
                    end
                end else begin
                    o_cmd.ptr_op = bbc_pkg::PTR_INC;
                end
            end
            default: n_state = bbc_pkg::S_IDLE;
        endcase
    end

endmodule

// File: src/block_buffer_cache_lru_core.sv
// Top level of the block buffer cache tag manager: controller, datapath and
// the request and result channels. Depends on bbc_pkg, bbc_req_if, bbc_res_if,
// bbc_ctrl and bbc_dpath.
//
// Tag manager of an 8-slot buffer pool with least-recently-used replacement.
// One request is handled at a time; ready is high only while the block waits
// for a request, and a finished result may sit in the output register while
// the next request is taken. The tag store has a single read port, so an
// acquire or zero-buffer request scans the slots one per cycle, then goes
// through the decide and emit states, with a named dirty victim written back
// in a result of its own before the fill or clear. A release goes from
// dispatch straight to its result. A sync walks the slots upward from slot 0
// and ends with the last reported one, or gives a single result when none is
// named and dirty. Results wait for the sink whenever the output register is full.
module block_buffer_cache_lru_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_res_if.source o_res
);

    bbc_pkg::t_cmd     w_cmd;
    bbc_pkg::t_stat    w_stat;
    bbc_pkg::t_req_pay w_req;
    bbc_pkg::t_res_pay w_out;
    logic              w_out_valid;
    logic              w_ready;

    // Request payload
    always_comb begin
        w_req.kind        = i_req.kind;
        w_req.device      = i_req.device;
        w_req.block       = i_req.block;
        w_req.fill_mode   = i_req.fill_mode;
        w_req.slot        = i_req.slot;
        w_req.dirty_level = i_req.dirty_level;
    end
    assign i_req.ready = w_ready;

    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_req_ready (w_ready),
        .o_cmd       (w_cmd)
    );

    bbc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (w_req),
        .i_out_ready (o_res.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    // Result channel
    assign o_res.valid        = w_out_valid;
    assign o_res.slot_used    = w_out.slot_used;
    assign o_res.hit          = w_out.hit;
    assign o_res.fill_read    = w_out.fill_read;
    assign o_res.clear_data   = w_out.clear_data;
    assign o_res.write_out    = w_out.write_out;
    assign o_res.write_device = w_out.write_device;
    assign o_res.write_block  = w_out.write_block;
    assign o_res.status       = w_out.status;
    assign o_res.last         = w_out.last;

    // A result is only emitted when the output register has room
    a_emit_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.res != bbc_pkg::RES_NONE) |-> w_stat.out_space)
        else $error("result emitted into a full output register");

    // No result is emitted while a new request may be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ready |-> (w_cmd.res == bbc_pkg::RES_NONE))
        else $error("result emitted while waiting for a request");

    // The tag scan never runs while the request channel is open
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |-> !w_ready)
        else $error("tag scan while accepting a request");

    // An accepted request is always dispatched in the next cycle
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && w_ready) |=> !w_ready)
        else $error("request channel still open after acceptance");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench of block_buffer_cache_lru_core: a directed table, then random requests, each
// checked against a tag-store predictor. Depends on the core, bbc_pkg, bbc_req_if, bbc_res_if.
module tb_top;

    localparam int         DIR_ROWS    = 25;
    localparam int         RAND_ITEMS  = 385;
    localparam int         HOLD_AT     = 80;    // request index that starts the output hold-off
    localparam int         HOLD_LEN    = 300;
    localparam int         CALM_FROM   = 180;   // stretch with no idling on either side
    localparam int         CALM_LEN    = 100;
    localparam int         TAIL_CYCLES = 24;
    localparam int         STALL_LIMIT = 3000;
    localparam logic [1:0] FILL_ALIAS  = 2'd3;  // behaves as a rewrite
    localparam logic [1:0] LVL_ALIAS   = 2'd3;  // behaves as mark dirty

    typedef struct packed {
        bbc_pkg::t_req_pay req;
        logic              typed;
        bbc_pkg::t_res_pay want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bbc_req_if req_ch ();
    bbc_res_if res_ch ();

    block_buffer_cache_lru_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Predicted tag store
    bit                           tag_named [bbc_pkg::SLOT_COUNT];
    bit [7:0]                     tag_dev   [bbc_pkg::SLOT_COUNT];
    bit [bbc_pkg::BLOCK_BITS-1:0] tag_blk   [bbc_pkg::SLOT_COUNT];
    bit                           tag_dirty [bbc_pkg::SLOT_COUNT];
    bit                           tag_busy  [bbc_pkg::SLOT_COUNT];
    bit [bbc_pkg::STAMP_BITS-1:0] tag_stamp [bbc_pkg::SLOT_COUNT];
    bit [bbc_pkg::STAMP_BITS-1:0] use_clk;

    bbc_pkg::t_res_pay due_res  [$];    // results still owed by the block, oldest first
    bbc_pkg::t_res_pay step_res [$];    // results of the request just accepted
    t_dir_row          dir_tab  [DIR_ROWS];

    int errors      = 0;
    int idle_cycles = 0;
    bit hold_go     = 1'b0;
    bit calm        = 1'b0;

    function automatic bbc_pkg::t_req_pay mk_req(bbc_pkg::t_kind kind, logic [7:0] dev,
                                                 logic [15:0] blk, logic [1:0] mode,
                                                 logic [2:0] slot, logic [1:0] lvl);
        bbc_pkg::t_req_pay r;
        r.kind        = kind;
        r.device      = dev;
        r.block       = blk;
        r.fill_mode   = mode;
        r.slot        = slot;
        r.dirty_level = lvl;
        return r;
    endfunction

    function automatic bbc_pkg::t_res_pay mk_res(int slot, bit hit, bit fill, bit clr, bit wr,
                                                 logic [7:0] wdev, logic [15:0] wblk,
                                                 logic [1:0] st, bit last);
        bbc_pkg::t_res_pay p;
        p.slot_used    = 3'(slot);
        p.hit          = hit;
        p.fill_read    = fill;
        p.clear_data   = clr;
        p.write_out    = wr;
        p.write_device = wdev;
        p.write_block  = wblk;
        p.status       = st;
        p.last         = last;
        return p;
    endfunction

    // Idle slot of greatest modular age; the later slot wins a tie, -1 if all busy
    function automatic int oldest_idle();
        int                           best;
        int                           i;
        bit [bbc_pkg::STAMP_BITS-1:0] best_age;
        bit [bbc_pkg::STAMP_BITS-1:0] age;
        best     = -1;
        best_age = '0;
        for (i = 0; i < bbc_pkg::SLOT_COUNT; i++) begin
            age = use_clk - tag_stamp[i];
            if (!tag_busy[i] && (best < 0 || age >= best_age)) begin
                best     = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    // A dirty victim is written back only if it is named; dirty is dropped either way
    function automatic void write_back(int v);
        if (tag_dirty[v]) begin
            if (tag_named[v])
                step_res.push_back(mk_res(v, 0, 0, 0, 1, tag_dev[v], tag_blk[v],
                                          bbc_pkg::ST_OK, 0));
            tag_dirty[v] = 1'b0;
        end
    endfunction

    // Apply one request to the predicted tags and collect its results
    function automatic void tag_update(bbc_pkg::t_req_pay r);
        int hit_at;
        int v;
        int k;
        int i;
        step_res.delete();
        case (r.kind)
            bbc_pkg::KIND_ACQUIRE: begin
                hit_at = -1;
                for (i = bbc_pkg::SLOT_COUNT - 1; i >= 0; i--)
                    if (tag_named[i] && tag_dev[i] == r.device &&
                        tag_blk[i] == r.block[bbc_pkg::BLOCK_BITS-1:0])
                        hit_at = i;
                if (hit_at >= 0 && tag_busy[hit_at]) begin
                    step_res.push_back(mk_res(hit_at, 1, 0, 0, 0, 0, 0, bbc_pkg::ST_BUSY, 1));
                end else if (hit_at >= 0) begin
                    use_clk           = use_clk + 1'b1;
                    tag_stamp[hit_at] = use_clk;
                    tag_busy[hit_at]  = 1'b1;
                    step_res.push_back(mk_res(hit_at, 1, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1));
                end else begin
                    v = oldest_idle();
                    if (v < 0) begin
                        step_res.push_back(mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_NOBUF, 1));
                    end else begin
                        write_back(v);
                        tag_named[v] = 1'b1;
                        tag_dev[v]   = r.device;
                        tag_blk[v]   = r.block[bbc_pkg::BLOCK_BITS-1:0];
                        tag_busy[v]  = 1'b1;
                        use_clk      = use_clk + 1'b1;
                        tag_stamp[v] = use_clk;
                        step_res.push_back(mk_res(v, 0, r.fill_mode == bbc_pkg::FILL_READ,
                                                  r.fill_mode == bbc_pkg::FILL_ZERO, 0, 0, 0,
                                                  bbc_pkg::ST_OK, 1));
                    end
                end
            end
            bbc_pkg::KIND_RELEASE: begin
                i = int'(r.slot);
                if (i >= bbc_pkg::SLOT_COUNT) begin
                    step_res.push_back(mk_res(i, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1));
                end else begin
                    if (r.dirty_level != bbc_pkg::LVL_CLEAN)
                        tag_dirty[i] = 1'b1;
                    tag_busy[i] = 1'b0;
                    if (r.dirty_level == bbc_pkg::LVL_WRITE) begin
                        // unnamed slot: no write, dirty just dropped
                        step_res.push_back(mk_res(i, 0, 0, 0, tag_named[i],
                                                  tag_named[i] ? tag_dev[i] : 8'd0,
                                                  tag_named[i] ? tag_blk[i] : 16'd0,
                                                  bbc_pkg::ST_OK, 1));
                        tag_dirty[i] = 1'b0;
                    end else begin
                        step_res.push_back(mk_res(i, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1));
                    end
                end
            end
            bbc_pkg::KIND_ZERO: begin
                v = oldest_idle();
                if (v < 0) begin
                    step_res.push_back(mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_NOBUF, 1));
                end else begin
                    write_back(v);
                    tag_named[v] = 1'b0;
                    step_res.push_back(mk_res(v, 0, 0, 1, 0, 0, 0, bbc_pkg::ST_OK, 1));
                end
            end
            default: begin
                // sync: every named dirty slot, ascending, dirty kept
                k = 0;
                for (i = 0; i < bbc_pkg::SLOT_COUNT; i++)
                    if (k < bbc_pkg::RESULT_LIMIT && tag_named[i] && tag_dirty[i]) begin
                        step_res.push_back(mk_res(i, 0, 0, 0, 1, tag_dev[i], tag_blk[i],
                                                  bbc_pkg::ST_OK, 0));
                        k++;
                    end
                if (k == 0)
                    step_res.push_back(mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1));
                else
                    step_res[k-1].last = 1'b1;
            end
        endcase
    endfunction

    // Mostly acquires over a small set of names and releases of busy slots
    function automatic bbc_pkg::t_req_pay rand_req();
        bbc_pkg::t_req_pay r;
        int                pick;
        int                s;
        int                i;
        bit                found;
        r.kind        = bbc_pkg::KIND_SYNC;
        r.device      = 8'($urandom);
        r.block       = 16'($urandom);
        r.fill_mode   = 2'($urandom);
        r.slot        = 3'($urandom);
        r.dirty_level = 2'($urandom);
        pick          = $urandom_range(0, 99);
        if (pick < 45) begin
            r.kind = bbc_pkg::KIND_ACQUIRE;
            if ($urandom_range(0, 4) != 0) begin
                r.device = 8'($urandom_range(0, 1));
                r.block  = 16'($urandom_range(0, 7));
            end
        end else if (pick < 80) begin
            r.kind = bbc_pkg::KIND_RELEASE;
            if ($urandom_range(0, 6) != 0) begin
                s     = $urandom_range(0, bbc_pkg::SLOT_COUNT - 1);
                found = 1'b0;
                for (i = 0; i < bbc_pkg::SLOT_COUNT; i++)
                    if (!found && tag_busy[(s + i) % bbc_pkg::SLOT_COUNT]) begin
                        r.slot = 3'((s + i) % bbc_pkg::SLOT_COUNT);
                        found  = 1'b1;
                    end
            end
        end else if (pick < 90) begin
            r.kind = bbc_pkg::KIND_ZERO;
        end
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then log what it owes
    task automatic offer(bbc_pkg::t_req_pay r, bit typed, bbc_pkg::t_res_pay want);
        if (!calm && $urandom_range(0, 99) < 25) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= r.kind;
        req_ch.device      <= r.device;
        req_ch.block       <= r.block;
        req_ch.fill_mode   <= r.fill_mode;
        req_ch.slot        <= r.slot;
        req_ch.dirty_level <= r.dirty_level;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        tag_update(r);
        if (typed)
            due_res.push_back(want);
        else
            foreach (step_res[j]) due_res.push_back(step_res[j]);
    endtask

    task automatic field_check(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random stalls, one long hold-off, a calm stretch
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // Compare each result taken with the oldest one owed
    always @(posedge i_clk) begin : res_check
        bbc_pkg::t_res_pay got;
        bbc_pkg::t_res_pay want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.slot_used    = res_ch.slot_used;
            got.hit          = res_ch.hit;
            got.fill_read    = res_ch.fill_read;
            got.clear_data   = res_ch.clear_data;
            got.write_out    = res_ch.write_out;
            got.write_device = res_ch.write_device;
            got.write_block  = res_ch.write_block;
            got.status       = res_ch.status;
            got.last         = res_ch.last;
            if (due_res.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = due_res.pop_front();
                field_check("slot_used", 16'(want.slot_used), 16'(got.slot_used));
                field_check("hit", 16'(want.hit), 16'(got.hit));
                field_check("fill_read", 16'(want.fill_read), 16'(got.fill_read));
                field_check("clear_data", 16'(want.clear_data), 16'(got.clear_data));
                field_check("write_out", 16'(want.write_out), 16'(got.write_out));
                field_check("write_device", 16'(want.write_device), 16'(got.write_device));
                field_check("write_block", want.write_block, got.write_block);
                field_check("status", 16'(want.status), 16'(got.status));
                field_check("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // Watchdog: cycles with no request or result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin : stim
        int n;
        // Walk from reset through every path; typed rows follow straight from reset state
        dir_tab[0]  = '{mk_req(bbc_pkg::KIND_SYNC, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b1,
                        mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1)};
        dir_tab[1]  = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 7,
                               bbc_pkg::LVL_CLEAN), 1'b1,
                        mk_res(7, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1)};
        // write request on an unnamed slot: no write
        dir_tab[2]  = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_WRITE), 1'b1,
                        mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1)};
        // leaves slot 1 dirty but unnamed
        dir_tab[3]  = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 1,
                               bbc_pkg::LVL_DIRTY), 1'b1,
                        mk_res(1, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK, 1)};
        // all ages equal: highest slot wins
        dir_tab[4]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b1,
                        mk_res(7, 0, 1, 0, 0, 0, 0, bbc_pkg::ST_OK, 1)};
        dir_tab[5]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 8'hFF, 16'hFFFF, bbc_pkg::FILL_ZERO, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[6]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 8'hFF, 16'hFFFF, bbc_pkg::FILL_READ, 7,
                               bbc_pkg::LVL_WRITE), 1'b0, '0};
        dir_tab[7]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 1, 1, FILL_ALIAS, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[8]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 2, 2, bbc_pkg::FILL_REWRITE, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[9]  = '{mk_req(bbc_pkg::KIND_ACQUIRE, 3, 3, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[10] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 4, 4, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        // victim is slot 1, dirty and unnamed: no write-back
        dir_tab[11] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 5, 5, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[12] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 6, 6, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        // pool fully busy
        dir_tab[13] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 7, 7, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b1,
                        mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_NOBUF, 1)};
        dir_tab[14] = '{mk_req(bbc_pkg::KIND_ZERO, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b1,
                        mk_res(0, 0, 0, 0, 0, 0, 0, bbc_pkg::ST_NOBUF, 1)};
        dir_tab[15] = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 6,
                               LVL_ALIAS), 1'b0, '0};
        dir_tab[16] = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 4,
                               bbc_pkg::LVL_WRITE), 1'b0, '0};
        dir_tab[17] = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 5,
                               bbc_pkg::LVL_DIRTY), 1'b0, '0};
        dir_tab[18] = '{mk_req(bbc_pkg::KIND_SYNC, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[19] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 8'hFF, 16'hFFFF, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        // zero buffer over a dirty named victim
        dir_tab[20] = '{mk_req(bbc_pkg::KIND_ZERO, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[21] = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 7,
                               bbc_pkg::LVL_DIRTY), 1'b0, '0};
        // acquire over a dirty named victim: write-back then fill
        dir_tab[22] = '{mk_req(bbc_pkg::KIND_ACQUIRE, 9, 9, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[23] = '{mk_req(bbc_pkg::KIND_SYNC, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};
        dir_tab[24] = '{mk_req(bbc_pkg::KIND_RELEASE, 0, 0, bbc_pkg::FILL_READ, 0,
                               bbc_pkg::LVL_CLEAN), 1'b0, '0};

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= '0;
        req_ch.device      <= '0;
        req_ch.block       <= '0;
        req_ch.fill_mode   <= '0;
        req_ch.slot        <= '0;
        req_ch.dirty_level <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++)
            offer(dir_tab[n].req, dir_tab[n].typed, dir_tab[n].want);

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT)
                hold_go = 1'b1;
            calm = (n >= CALM_FROM) && (n < CALM_FROM + CALM_LEN);
            offer(rand_req(), 1'b0, '0);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (due_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/bbc_pkg.sv
src/bbc_req_if.sv
src/bbc_res_if.sv
src/bbc_dpath.sv
src/bbc_ctrl.sv
src/block_buffer_cache_lru_core.sv
tb/tb_top.sv
